// ===== rtl/rau_pkg.sv =====
`default_nettype none
package rau_pkg;

    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_MUL = 2'd1,
        KIND_DIV = 2'd2,
        KIND_NEG = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] left_num;
        logic [30:0]        left_den;
        logic signed [31:0] right_num;
        logic [30:0]        right_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic [1:0]         status;
    } rau_out_t;

endpackage
`default_nettype wire

// ===== rtl/rau_gcd.sv =====
`default_nettype none
// Binary gcd of two nonzero 63-bit magnitudes, one subtract or shift per cycle.
module rau_gcd
    import rau_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [62:0] a_in,
    input  wire logic [62:0] b_in,
    output logic             done,
    output logic [62:0]      gcd
);

    typedef enum logic [3:0] {
        G_IDLE  = 4'b0001,
        G_TWOS  = 4'b0010,
        G_RUN   = 4'b0100,
        G_SHIFT = 4'b1000
    } gst_t;

    gst_t        state_reg, state_next;
    logic [62:0] a_reg, a_next, b_reg, b_next;
    logic [5:0]  sh_reg, sh_next;

    always_comb begin
        state_next = state_reg;
        a_next = a_reg;
        b_next = b_reg;
        sh_next = sh_reg;
        done = 1'b0;
        unique case (state_reg)
            G_IDLE: begin
                if (start) begin
                    a_next = a_in;
                    b_next = b_in;
                    sh_next = '0;
                    state_next = G_TWOS;
                end
            end
            G_TWOS: begin
                if (((a_reg | b_reg) & 63'd1) == 63'd0) begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    sh_next = sh_reg + 6'd1;
                end else begin
                    state_next = G_RUN;
                end
            end
            G_RUN: begin
                // one step: drop a factor of two, else subtract smaller from larger
                if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end else if (b_reg == '0) begin
                    state_next = G_SHIFT;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (a_reg > b_reg) begin
                    a_next = b_reg;
                    b_next = a_reg - b_reg;
                end else begin
                    b_next = b_reg - a_reg;
                end
            end
            G_SHIFT: begin
                if (sh_reg != '0) begin
                    a_next = a_reg << 1;
                    sh_next = sh_reg - 6'd1;
                end else begin
                    done = 1'b1;
                    state_next = G_IDLE;
                end
            end
            default: state_next = G_IDLE;
        endcase
    end

    assign gcd = a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_IDLE;
        end else begin
            state_reg <= state_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        sh_reg <= sh_next;
    end

endmodule
`default_nettype wire

// ===== rtl/rau_div.sv =====
`default_nettype none
// Restoring divider for 63-bit operands, one quotient bit per cycle.
module rau_div
    import rau_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [62:0] dividend,
    input  wire logic [62:0] divisor,
    output logic             done,
    output logic [62:0]      quotient
);

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [62:0] q_reg, r_reg, d_reg;
    logic [63:0] trial;

    assign trial = {r_reg, q_reg[62]} - {1'b0, d_reg};
    assign done = busy_reg && cnt_reg == 6'd0;
    assign quotient = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= 6'd63;
        end else if (busy_reg) begin
            if (cnt_reg == 6'd0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg && cnt_reg != 6'd0) begin
            if (!trial[63]) begin
                r_reg <= trial[62:0];
                q_reg <= {q_reg[61:0], 1'b1};
            end else begin
                r_reg <= {r_reg[61:0], q_reg[62]};
                q_reg <= {q_reg[61:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rational_arith_unit_core.sv =====
`default_nettype none
// Rational arithmetic unit: add, multiply or divide two fractions and reduce
// the result by the greatest common divisor, or negate one fraction unreduced.
// Input channel s_valid/s_ready/s_data carries kind and both operands; result
// channel m_valid/m_ready/m_data carries the reduced fraction and a status.
// One item at a time: s_ready is low from acceptance until the result is
// taken. The products are formed by one 32x32 multiplier in S_MUL0 and S_MUL1
// (and S_MUL2 for add), the binary gcd does one shift or subtract step per
// cycle, and each exact division by the gcd runs on a shared one-bit-per-cycle
// divider. Negate, zero and divide-by-zero results skip the gcd and both
// divisions.
// Reset returns the sequencer to idle with no result pending. A stalled
// receiver holds m_valid and m_data; no new item is taken meanwhile.
// Status reports divide by zero or a result beyond WORD_BITS; both give 0/1.
module rational_arith_unit_core
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire rau_in_t s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output rau_out_t  m_data
);

    localparam logic [63:0] LIM = (64'd1 << (WORD_BITS - 1)) - 64'd1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL0  = 10'b0000000010,
        S_MUL1  = 10'b0000000100,
        S_MUL2  = 10'b0000001000,
        S_FORM  = 10'b0000010000,
        S_GCD   = 10'b0000100000,
        S_DIVN  = 10'b0001000000,
        S_DIVD  = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg;
    rau_in_t in_reg;
    logic signed [63:0] p0_reg, p1_reg;
    logic [62:0] nm_reg, dm_reg, g_reg;
    logic neg_reg;
    logic [1:0] st_reg;
    rau_out_t out_reg;

    // shared multiplier
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    always_comb begin
        ma = in_reg.left_num;
        mb = $signed({1'b0, in_reg.right_den});
        case (state_reg)
            S_MUL0: begin
                ma = in_reg.left_num;
                mb = (in_reg.kind == KIND_MUL) ? in_reg.right_num
                                               : $signed({1'b0, in_reg.right_den});
            end
            S_MUL2: begin
                ma = in_reg.right_num;
                mb = $signed({1'b0, in_reg.left_den});
            end
            default: begin
                ma = $signed({1'b0, in_reg.left_den});
                mb = (in_reg.kind == KIND_DIV) ? in_reg.right_num
                                               : $signed({1'b0, in_reg.right_den});
            end
        endcase
    end
    assign prod = ma * mb;

    logic signed [63:0] n_full;
    logic [63:0] nmag, dmag;
    always_comb begin
        n_full = p0_reg;
        nmag = n_full[63] ? 64'd0 - n_full : n_full;
        dmag = p1_reg[63] ? 64'd0 - p1_reg : p1_reg;
    end

    logic gcd_start, gcd_done;
    logic [62:0] gcd_val;
    rau_gcd u_gcd (
        .aclk(aclk), .aresetn(aresetn), .start(gcd_start),
        .a_in(nmag[62:0]), .b_in(dmag[62:0]), .done(gcd_done), .gcd(gcd_val)
    );

    logic div_start, div_done;
    logic [62:0] div_q;
    rau_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend((state_reg == S_GCD) ? nm_reg : dm_reg),
        .divisor((state_reg == S_GCD) ? gcd_val : g_reg),
        .done(div_done), .quotient(div_q)
    );

    logic [63:0] nlim;
    logic ovf;
    always_comb begin
        nlim = neg_reg ? LIM + 64'd1 : LIM;
        ovf = ({1'b0, nm_reg} > nlim) || ({1'b0, dm_reg} > LIM) || dm_reg == '0;
    end

    logic n_is_zero;
    assign n_is_zero = (nmag == 64'd0);
    assign gcd_start = (state_reg == S_FORM) && p1_reg != '0 && !n_is_zero;
    assign div_start = (state_reg == S_GCD && gcd_done) || (state_reg == S_DIVN && div_done);
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_valid) state_reg <= S_MUL0;
                S_MUL0: state_reg <= S_MUL1;
                S_MUL1: state_reg <= (in_reg.kind == KIND_NEG) ? S_EMIT :
                                     (in_reg.kind == KIND_ADD) ? S_MUL2 : S_FORM;
                S_MUL2: state_reg <= S_FORM;
                S_FORM: state_reg <= gcd_start ? S_GCD : S_EMIT;
                S_GCD:  if (gcd_done) state_reg <= S_DIVN;
                S_DIVN: if (div_done) state_reg <= S_DIVD;
                S_DIVD: if (div_done) state_reg <= S_EMIT;
                S_EMIT: state_reg <= S_OUT;
                S_OUT:  if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
        case (state_reg)
            S_IDLE: if (s_valid) in_reg <= s_data;
            S_MUL0: p0_reg <= prod;
            S_MUL1: begin
                p1_reg <= prod;
                st_reg <= ST_OK;
                if (in_reg.kind == KIND_NEG) begin
                    // pass through unreduced
                    neg_reg <= in_reg.left_num > 0;
                    nm_reg <= in_reg.left_num[31] ? 63'(64'd0 - 64'(signed'(in_reg.left_num)))
                                                  : 63'(in_reg.left_num);
                    dm_reg <= 63'(in_reg.left_den);
                    if (in_reg.left_den == '0) st_reg <= ST_DIVZERO;
                end
            end
            // accumulate the cross product for add
            S_MUL2: p0_reg <= p0_reg + prod;
            S_FORM: begin
                nm_reg <= nmag[62:0];
                dm_reg <= dmag[62:0];
                neg_reg <= n_full[63] != p1_reg[63];
                if (p1_reg == '0) begin
                    st_reg <= ST_DIVZERO;
                end else if (n_is_zero) begin
                    nm_reg <= '0;
                    dm_reg <= 63'd1;
                    neg_reg <= 1'b0;
                end
            end
            S_GCD: if (gcd_done) g_reg <= gcd_val;
            S_DIVN: if (div_done) nm_reg <= div_q;
            S_DIVD: if (div_done) dm_reg <= div_q;
            S_EMIT: begin
                if (st_reg != ST_OK || ovf) begin
                    out_reg.res_num <= '0;
                    out_reg.res_den <= 31'd1;
                    out_reg.status <= (st_reg != ST_OK) ? st_reg : ST_OVERFLOW;
                end else begin
                    out_reg.res_num <= neg_reg ? 32'(64'd0 - {1'b0, nm_reg})
                                               : nm_reg[31:0];
                    out_reg.res_den <= dm_reg[30:0];
                    out_reg.status <= ST_OK;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/rau_checker.sv =====
`default_nettype none
module rau_checker
    import rau_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire rau_in_t  s_data,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire rau_out_t m_data
);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while result pending");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped under stall");

    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.res_den == 31'd1 && m_data.res_num == '0)
        else $error("error result not 0/1");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("ready right after transfer");

endmodule

bind rational_arith_unit_core rau_checker u_rau_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top
    import rau_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RANDOM_ITEMS   = 1400;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    rau_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    rau_out_t m_data;

    rational_arith_unit_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    rau_out_t fraction_q[$];
    int       error_count;
    int       table_errors;
    int       sent_count;
    int       recv_count;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       draining;
    int       status_hits[3];

    // Binary gcd on magnitudes.
    function automatic logic [63:0] gcd_mag(logic [63:0] a, logic [63:0] b);
        int unsigned sh;
        logic [63:0] t;
        sh = 0;
        if (a == 0) return b;
        if (b == 0) return a;
        while (((a | b) & 64'd1) == 0) begin
            a = a >> 1;
            b = b >> 1;
            sh++;
        end
        while ((a & 64'd1) == 0) a = a >> 1;
        while (b != 0) begin
            while ((b & 64'd1) == 0) b = b >> 1;
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            b = b - a;
        end
        return a << sh;
    endfunction

    function automatic rau_out_t pack_fraction(bit neg, logic [63:0] nmag,
                                               logic [63:0] dmag, status_t st);
        rau_out_t r;
        logic [63:0] lim;
        logic [63:0] nlim;
        logic [63:0] sn;
        lim  = (64'd1 << 31) - 1;
        nlim = neg ? lim + 1 : lim;
        if (st == ST_OK && (nmag > nlim || dmag > lim || dmag == 0)) st = ST_OVERFLOW;
        if (st != ST_OK) begin
            r.res_num = 32'sd0;
            r.res_den = 31'd1;
            r.status  = st;
            return r;
        end
        sn = neg ? (64'd0 - nmag) : nmag;
        r.res_num = sn[31:0];
        r.res_den = dmag[30:0];
        r.status  = ST_OK;
        return r;
    endfunction

    function automatic rau_out_t reduce_fraction(rau_in_t it);
        longint ln, ld, rn, rd, n, d;
        logic [63:0] nm, dm, g;
        bit neg;
        ln = longint'(it.left_num);
        ld = longint'({1'b0, it.left_den});
        rn = longint'(it.right_num);
        rd = longint'({1'b0, it.right_den});
        if (kind_t'(it.kind) == KIND_NEG) begin
            if (ld == 0) return pack_fraction(1'b0, 0, 1, ST_DIVZERO);
            n   = -ln;
            neg = n < 0;
            nm  = neg ? -n : n;
            return pack_fraction(neg, nm, ld, ST_OK);
        end
        case (kind_t'(it.kind))
            KIND_ADD: begin
                n = ln * rd + rn * ld;
                d = ld * rd;
            end
            KIND_MUL: begin
                n = ln * rn;
                d = ld * rd;
            end
            default: begin
                n = ln * rd;
                d = ld * rn;
            end
        endcase
        if (d == 0) return pack_fraction(1'b0, 0, 1, ST_DIVZERO);
        neg = (n < 0) != (d < 0);
        nm  = n < 0 ? -n : n;
        dm  = d < 0 ? -d : d;
        if (nm == 0) return pack_fraction(1'b0, 0, 1, ST_OK);
        g = gcd_mag(nm, dm);
        return pack_fraction(neg, nm / g, dm / g, ST_OK);
    endfunction

    // Result side: random stall, compare against oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                recv_count++;
                if (fraction_q.size() == 0) begin
                    $display("%0t: unexpected result num=%0d den=%0d st=%0d", $time,
                             m_data.res_num, m_data.res_den, m_data.status);
                    error_count++;
                end else begin
                    rau_out_t e;
                    e = fraction_q.pop_front();
                    if (m_data.status < 3) status_hits[m_data.status]++;
                    if (e.res_num !== m_data.res_num || e.res_den !== m_data.res_den ||
                        e.status !== m_data.status) begin
                        $display("%0t: mismatch expected %0d/%0d st=%0d actual %0d/%0d st=%0d",
                                 $time, e.res_num, e.res_den, e.status,
                                 m_data.res_num, m_data.res_den, m_data.status);
                        error_count++;
                    end
                end
            end
            m_ready <= draining ? 1'b1 : ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_num();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'(signed'($urandom_range(20)) - 10);
            4: return 32'(signed'($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_den();
        case ($urandom_range(7))
            0: return 31'h7FFF_FFFF;
            1: return 31'd1;
            2: return ($urandom_range(30) == 0) ? 31'd0 : 31'd2;
            3: return 31'($urandom_range(12) + 1);
            4: return 31'($urandom_range(1000) + 1);
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic send_item(rau_in_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        fraction_q.push_back(reduce_fraction(it));
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic wait_empty();
        s_valid <= 1'b0;
        while (fraction_q.size() != 0) @(posedge aclk);
    endtask

    typedef struct {
        rau_in_t  item;
        bit       known;
        rau_out_t want;
    } vector_t;

    vector_t directed[$];

    function automatic rau_in_t mk(kind_t k, int ln, int ld, int rn, int rd);
        rau_in_t it;
        it.kind      = k;
        it.left_num  = ln;
        it.left_den  = ld[30:0];
        it.right_num = rn;
        it.right_den = rd[30:0];
        return it;
    endfunction

    function automatic rau_out_t fr(int n, int d, status_t st);
        rau_out_t r;
        r.res_num = n;
        r.res_den = d[30:0];
        r.status  = st;
        return r;
    endfunction

    task automatic add_row(rau_in_t it, bit known, rau_out_t want);
        vector_t v;
        v.item  = it;
        v.known = known;
        v.want  = want;
        directed.push_back(v);
    endtask

    initial begin
        rau_in_t it;
        rau_out_t none;
        int phase;
        none = '0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        table_errors = 0;
        sent_count  = 0;
        draining    = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 78;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(mk(KIND_ADD, 1, 2, 1, 3), 1, fr(5, 6, ST_OK));
        add_row(mk(KIND_MUL, 2, 3, 3, 4), 1, fr(1, 2, ST_OK));
        add_row(mk(KIND_DIV, 1, 2, 0, 1), 1, fr(0, 1, ST_DIVZERO));
        add_row(mk(KIND_DIV, 3, 4, -3, 1), 1, fr(-1, 4, ST_OK));
        add_row(mk(KIND_NEG, 0, 7, 0, 1), 1, fr(0, 7, ST_OK));
        add_row(mk(KIND_NEG, 32'h8000_0000, 1, 0, 1), 1, fr(0, 1, ST_OVERFLOW));
        add_row(mk(KIND_NEG, 5, 0, 0, 1), 1, fr(0, 1, ST_DIVZERO));
        add_row(mk(KIND_ADD, 1, 0, 1, 1), 1, fr(0, 1, ST_DIVZERO));
        add_row(mk(KIND_MUL, 1, 1, 1, 0), 1, fr(0, 1, ST_DIVZERO));
        add_row(mk(KIND_ADD, 1, 2, -1, 2), 1, fr(0, 1, ST_OK));
        add_row(mk(KIND_MUL, 32'h7FFF_FFFF, 1, 2, 1), 1, fr(0, 1, ST_OVERFLOW));
        add_row(mk(KIND_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1), 1,
                fr(0, 1, ST_OVERFLOW));
        add_row(mk(KIND_NEG, -7, 32'h7FFF_FFFF, 0, 1), 1, fr(7, 32'h7FFF_FFFF, ST_OK));
        add_row(mk(KIND_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF), 0, none);
        add_row(mk(KIND_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF), 0, none);
        add_row(mk(KIND_DIV, 32'h8000_0000, 1, -1, 1), 1, fr(0, 1, ST_OVERFLOW));
        add_row(mk(KIND_DIV, 32'h8000_0000, 1, 1, 1), 1, fr(32'h8000_0000, 1, ST_OK));
        add_row(mk(KIND_MUL, 6, 35, 14, 15), 0, none);
        add_row(mk(KIND_ADD, -1, 6, -1, 3), 1, fr(-1, 2, ST_OK));

        foreach (directed[i]) begin
            if (directed[i].known &&
                reduce_fraction(directed[i].item) != directed[i].want) begin
                $display("%0t: table row %0d expected %0d/%0d st=%0d", $time, i,
                         directed[i].want.res_num, directed[i].want.res_den,
                         directed[i].want.status);
                table_errors++;
            end
            send_item(directed[i].item);
        end
        // Hold off until the unit drains.
        wait_empty();

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 78 : 0;
            recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 19 : 0;
            for (int k = 0; k < RANDOM_ITEMS / 3; k++) begin
                it.kind      = 2'($urandom_range(3));
                it.left_num  = pick_num();
                it.left_den  = pick_den();
                it.right_num = pick_num();
                it.right_den = pick_den();
                if ($urandom_range(9) == 0) it.right_den = 31'd1;
                send_item(it);
            end
        end

        draining = 1'b1;
        wait_empty();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("sent %0d items, checked %0d results (ok %0d, div-by-zero %0d, overflow %0d)",
                 sent_count, recv_count, status_hits[0], status_hits[1], status_hits[2]);
        $display("idle mixes: sender-heavy, receiver-heavy, none; %0d errors",
                 error_count + table_errors);
        if (error_count == 0 && table_errors == 0 && fraction_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/rau_pkg.sv
rtl/rau_gcd.sv
rtl/rau_div.sv
rtl/rational_arith_unit_core.sv
rtl/rau_checker.sv
tb/tb_top.sv
